// File: hdl/rbb_pkg.sv
// Shared package for the row box blur block: sizes, reset values,
// sequencer state type and the control bundles passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package rbb_pkg;

    // Default window limit and channel width
    localparam int MAX_RADIUS   = 15;
    localparam int CHANNEL_BITS = 16;

    // Colour channels per pixel: red, green, blue, alpha
    localparam int NUM_CH = 4;

    // Radius register: width fixed by the register map, reset value one
    localparam int                    RADIUS_BITS  = 4;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd1;

    // Result queue entries (power of two, pointers wrap naturally)
    localparam int FIFO_DEPTH = 8;

    // Sequencer: take pixels, or flush the tail of a finished row
    typedef enum logic [0:0] {
        SEQ_PIXEL,
        SEQ_FLUSH
    } seq_state_t;

    // One window operation as issued by the sequencer
    typedef struct packed {
        logic add;    // fold the new pixel into the sums
        logic drop;   // take the oldest pixel out of the sums
        logic emit;   // produce a result from the updated sums
        logic clear;  // zero the sums afterwards (row finished)
        logic done;   // result belongs to the row's final position
    } rbb_op_t;

    // Control that travels alongside a result through the divider
    typedef struct packed {
        logic valid;
        logic done;
    } rbb_ctl_t;

endpackage

// File: hdl/rbb_if.sv
// Channel interfaces for the row box blur block: pixel input, result
// output and the radius write channel. Depends on rbb_pkg.
`timescale 1ns / 1ps

interface rbb_pixel_if #(
    parameter int CHANNEL_BITS = rbb_pkg::CHANNEL_BITS
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] alpha_in;
    logic                    row_end;

    modport source (
        output valid, red_in, green_in, blue_in, alpha_in, row_end,
        input  ready
    );
    modport sink (
        input  valid, red_in, green_in, blue_in, alpha_in, row_end,
        output ready
    );
endinterface

interface rbb_result_if #(
    parameter int CHANNEL_BITS = rbb_pkg::CHANNEL_BITS
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic [CHANNEL_BITS-1:0] alpha_out;
    logic                    row_done;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, row_done,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, row_done,
        output ready
    );
endinterface

interface rbb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rbb_pkg::RADIUS_BITS-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: hdl/rbb_mean_div.sv
// Rounded window mean: (sum + count/2) / count for all four channels,
// by reciprocal multiply and one correction step, three register stages.
// Depends on rbb_pkg.
`timescale 1ns / 1ps

module rbb_mean_div #(
    parameter int  CHANNEL_BITS = rbb_pkg::CHANNEL_BITS,
    parameter int  MAX_RADIUS   = rbb_pkg::MAX_RADIUS,
    localparam int SUM_BITS     = CHANNEL_BITS + $clog2(2 * MAX_RADIUS + 1),
    localparam int CNT_BITS     = $clog2(2 * MAX_RADIUS + 2)
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  rbb_pkg::rbb_ctl_t                              in_ctl,
    input  logic [CNT_BITS-1:0]                            in_count,
    input  logic [rbb_pkg::NUM_CH-1:0][SUM_BITS-1:0]       in_sum,
    output rbb_pkg::rbb_ctl_t                              out_ctl,
    output logic [rbb_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]   out_mean
);

    localparam int NUM_CH     = rbb_pkg::NUM_CH;
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int TAB_SIZE   = 2 ** CNT_BITS;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam int QC_BITS    = CHANNEL_BITS + CNT_BITS;

    // Reciprocal table: floor(2^SUM_BITS / count). The estimate it gives is
    // never high and at most one low, for any dividend below 2^SUM_BITS.
    logic [RECIP_BITS-1:0] recip_tab [TAB_SIZE];

    assign recip_tab[0] = '0;
    for (genvar Cnt = 1; Cnt < TAB_SIZE; Cnt++)
    begin : g_recip
        localparam logic [63:0] Value = (64'd1 << SUM_BITS) / Cnt;
        assign recip_tab[Cnt] = RECIP_BITS'(Value);
    end

    // Stage A: rounded dividend and reciprocal
    rbb_pkg::rbb_ctl_t                       a_ctl_reg;
    logic [CNT_BITS-1:0]                     a_count_reg;
    logic [NUM_CH-1:0][SUM_BITS-1:0]         a_n_reg;
    logic [RECIP_BITS-1:0]                   a_recip_reg;

    // Stage B: dividend times reciprocal
    rbb_pkg::rbb_ctl_t                       b_ctl_reg;
    logic [CNT_BITS-1:0]                     b_count_reg;
    logic [NUM_CH-1:0][SUM_BITS-1:0]         b_n_reg;
    logic [NUM_CH-1:0][PROD_BITS-1:0]        b_prod_reg;

    // Stage C: quotient estimate and its back product
    rbb_pkg::rbb_ctl_t                       c_ctl_reg;
    logic [CNT_BITS-1:0]                     c_count_reg;
    logic [NUM_CH-1:0][SUM_BITS-1:0]         c_n_reg;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0]     c_q0_reg;
    logic [NUM_CH-1:0][QC_BITS-1:0]          c_qc_reg;

    logic [NUM_CH-1:0][CHANNEL_BITS-1:0]     q0_est;
    logic [NUM_CH-1:0][SUM_BITS-1:0]         rem;

    // Advance the control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= in_ctl;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
        end
    end

    // Take the high part of the product as the quotient estimate
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            q0_est[c] = CHANNEL_BITS'(b_prod_reg[c] >> SUM_BITS);
        end
    end

    // Advance the data path
    always_ff @(posedge clk)
    begin
        a_count_reg <= in_count;
        a_recip_reg <= recip_tab[in_count];
        b_count_reg <= a_count_reg;
        b_n_reg     <= a_n_reg;
        c_count_reg <= b_count_reg;
        c_n_reg     <= b_n_reg;
        c_q0_reg    <= q0_est;
        for (int c = 0; c < NUM_CH; c++)
        begin
            a_n_reg[c]    <= in_sum[c] + SUM_BITS'(in_count >> 1);
            b_prod_reg[c] <= PROD_BITS'(a_n_reg[c]) * PROD_BITS'(a_recip_reg);
            c_qc_reg[c]   <= QC_BITS'(q0_est[c]) * QC_BITS'(b_count_reg);
        end
    end

    // Correct the estimate upwards where the remainder reaches the divisor
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem[c] = c_n_reg[c] - SUM_BITS'(c_qc_reg[c]);
            if (rem[c] >= SUM_BITS'(c_count_reg))
            begin
                out_mean[c] = c_q0_reg[c] + CHANNEL_BITS'(1);
            end
            else
            begin
                out_mean[c] = c_q0_reg[c];
            end
        end
    end

    assign out_ctl = c_ctl_reg;

endmodule

// File: hdl/row_box_blur_edge_normalized.sv
// Top level of the row box blur: sequencer, window memory, running sums
// and result queue. Depends on rbb_pkg, rbb_if and rbb_mean_div.
`timescale 1ns / 1ps

// Centred 1-D box filter over an RGBA pixel stream. Each output is the
// per-channel mean over pixels p-r..p+r, clipped to the row, divided by
// the number of pixels inside the row and rounded to nearest (ties up).
// The result for position p leaves once pixel p+r has been taken; the
// pixel flagged row_end flushes the remaining results, at most r, the last one
// carrying row_done. The radius is sampled on the first pixel of each
// row and saturates at MAX_RADIUS. Rate: one pixel per cycle while the
// result side keeps up; a row end with radius r holds off pixels for
// r further window steps, one per flushed position, because every window step uses the single
// read port of the window memory. Results pass through the registered
// sum update and divider stages; an eight-entry result queue with credit
// tracking lets pixels keep flowing while results wait. The window
// memory needs no clearing pass, so the block is ready right after reset.
module row_box_blur_edge_normalized #(
    parameter int MAX_RADIUS   = rbb_pkg::MAX_RADIUS,
    parameter int CHANNEL_BITS = rbb_pkg::CHANNEL_BITS
) (
    input logic          clk,
    input logic          rst_n,
    rbb_cfg_if.sink      cfg,
    rbb_pixel_if.sink    pixel,
    rbb_result_if.source result
);

    localparam int NUM_CH     = rbb_pkg::NUM_CH;
    localparam int DEPTH      = 2 * MAX_RADIUS + 1;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int RAD_BITS   = $clog2(MAX_RADIUS + 1);
    localparam int SUM_BITS   = CHANNEL_BITS + $clog2(DEPTH);
    localparam int RW         = (RAD_BITS > rbb_pkg::RADIUS_BITS) ? RAD_BITS
                                                                  : rbb_pkg::RADIUS_BITS;
    localparam int FIFO_DEPTH = rbb_pkg::FIFO_DEPTH;
    localparam int FPTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int PEND_BITS  = $clog2(FIFO_DEPTH + 1);

    typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pix_t;
    typedef logic [NUM_CH-1:0][SUM_BITS-1:0]     sums_t;

    // Configuration
    logic [rbb_pkg::RADIUS_BITS-1:0] radius_reg;
    logic [RW-1:0]                   rad_wide;
    logic [RAD_BITS-1:0]             rad_sat;

    // Sequencer
    rbb_pkg::seq_state_t state_reg, state_next;
    logic [CNT_BITS-1:0] pos_reg;
    logic [CNT_BITS-1:0] last_pos_reg;
    logic [RAD_BITS-1:0] act_rad_reg;
    logic [RAD_BITS-1:0] k_reg;
    logic [ADDR_BITS-1:0] wptr_reg;
    logic [PEND_BITS-1:0] pend_reg, pend_next;
    logic                 room;
    logic                 pix_fire;

    // Operation decode
    logic [RAD_BITS-1:0] op_rad;
    logic [CNT_BITS-1:0] op_pos;
    logic [CNT_BITS-1:0] rad_c, twor, k_c, lim, twr_k;
    logic [CNT_BITS:0]   pos_plus_k;
    logic                op_fire;
    rbb_pkg::rbb_op_t    op;
    logic [CNT_BITS-1:0] op_count;
    logic [CNT_BITS-1:0] op_back;
    logic [ADDR_BITS:0]  raddr_wide;
    logic [ADDR_BITS-1:0] raddr;
    pix_t                pix_word;

    // Window memory
    pix_t window_store [DEPTH];
    pix_t rd_data_reg;

    // Sum update stage
    logic                s1_valid_reg;
    rbb_pkg::rbb_op_t    s1_op_reg;
    logic [CNT_BITS-1:0] s1_count_reg;
    pix_t                s1_pix_reg;
    sums_t               sum_reg, sum_next;
    sums_t               emit_sum_reg;
    rbb_pkg::rbb_ctl_t   em_ctl_reg;
    logic [CNT_BITS-1:0] em_count_reg;

    // Divider and result queue
    rbb_pkg::rbb_ctl_t    div_ctl;
    pix_t                 div_mean;
    pix_t                 fifo_mean [FIFO_DEPTH];
    logic                 fifo_done [FIFO_DEPTH];
    logic [FPTR_BITS-1:0] head_reg, tail_reg;
    logic [PEND_BITS-1:0] fifo_cnt_reg;
    logic                 fifo_rd;

    // Radius register: always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= rbb_pkg::RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            radius_reg <= cfg.data;
        end
    end

    // Saturate the programmed radius to the window limit
    assign rad_wide = RW'(radius_reg);
    assign rad_sat  = (rad_wide > RW'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                   : RAD_BITS'(rad_wide);

    // Credit: never issue more results than the queue can hold
    assign room        = pend_reg < PEND_BITS'(FIFO_DEPTH);
    assign pixel.ready = (state_reg == rbb_pkg::SEQ_PIXEL) && room;
    assign pix_fire    = pixel.valid && pixel.ready;

    // Radius and position of the current step
    assign op_rad = ((state_reg == rbb_pkg::SEQ_PIXEL) && (pos_reg == '0)) ? rad_sat
                                                                          : act_rad_reg;
    assign op_pos = (state_reg == rbb_pkg::SEQ_PIXEL) ? pos_reg : last_pos_reg;

    assign rad_c      = CNT_BITS'(op_rad);
    assign twor       = {rad_c[CNT_BITS-2:0], 1'b0};
    assign k_c        = CNT_BITS'(k_reg);
    assign lim        = twor + CNT_BITS'(1) - k_c;
    assign twr_k      = twor - k_c;
    assign pos_plus_k = {1'b0, op_pos} + (CNT_BITS + 1)'(k_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbb_pkg::SEQ_PIXEL:
            begin
                if (pix_fire && pixel.row_end && (op_rad != '0))
                begin
                    state_next = rbb_pkg::SEQ_FLUSH;
                end
            end
            rbb_pkg::SEQ_FLUSH:
            begin
                if (op_fire && op.done)
                begin
                    state_next = rbb_pkg::SEQ_PIXEL;
                end
            end
        endcase
    end

    // Decode the window operation of this cycle
    always_comb
    begin
        op_fire  = 1'b0;
        op       = '0;
        op_count = '0;
        op_back  = '0;
        unique case (state_reg)
            rbb_pkg::SEQ_PIXEL:
            begin
                op_fire  = pix_fire;
                op.add   = 1'b1;
                op.drop  = op_pos > twor;
                op.emit  = op_pos >= rad_c;
                op_count = ((op_pos < twor) ? op_pos : twor) + CNT_BITS'(1);
                op.done  = pixel.row_end && (op_rad == '0);
                op.clear = op.done;
                op_back  = twor + CNT_BITS'(1);
            end
            rbb_pkg::SEQ_FLUSH:
            begin
                op_fire  = room;
                op.drop  = op_pos >= lim;
                op.emit  = pos_plus_k >= {1'b0, rad_c};
                op_count = ((op_pos < twr_k) ? op_pos : twr_k) + CNT_BITS'(1);
                op.done  = k_reg == act_rad_reg;
                op.clear = op.done;
                op_back  = lim + CNT_BITS'(1);
            end
        endcase
    end

    // Address of the pixel leaving the window, op_back places behind the
    // write pointer (wraps inside the circular store)
    assign raddr_wide = (ADDR_BITS + 1)'(wptr_reg) + (ADDR_BITS + 1)'(DEPTH)
                      - (ADDR_BITS + 1)'(op_back);
    assign raddr      = (raddr_wide >= (ADDR_BITS + 1)'(DEPTH))
                      ? ADDR_BITS'(raddr_wide - (ADDR_BITS + 1)'(DEPTH))
                      : ADDR_BITS'(raddr_wide);

    assign pix_word = {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rbb_pkg::SEQ_PIXEL;
            pos_reg      <= '0;
            last_pos_reg <= '0;
            act_rad_reg  <= '0;
            k_reg        <= '0;
            wptr_reg     <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (pix_fire)
            begin
                last_pos_reg <= pos_reg;
                k_reg        <= RAD_BITS'(1);
                wptr_reg     <= (wptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0
                                                                    : wptr_reg + ADDR_BITS'(1);
                if (pos_reg == '0)
                begin
                    act_rad_reg <= rad_sat;
                end
                // Restart at a row end; saturate long rows at the window depth
                if (pixel.row_end)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg != CNT_BITS'(DEPTH))
                begin
                    pos_reg <= pos_reg + CNT_BITS'(1);
                end
            end
            else if (op_fire)
            begin
                k_reg <= k_reg + RAD_BITS'(1);
            end
        end
    end

    // Count results issued and not yet transferred out
    assign pend_next = pend_reg + PEND_BITS'(op_fire && op.emit) - PEND_BITS'(fifo_rd);

    // Window memory: read-first, so a read of the entry being overwritten
    // (full-width window) returns the pixel that leaves
    always_ff @(posedge clk)
    begin
        if (op_fire)
        begin
            rd_data_reg <= window_store[raddr];
        end
        if (pix_fire)
        begin
            window_store[wptr_reg] <= pix_word;
        end
    end

    // Hold the issued operation for the sum update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= op_fire;
            s1_op_reg    <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_count_reg <= op_count;
        s1_pix_reg   <= pix_word;
    end

    // Add the new pixel, drop the leaving one
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_next[c] = sum_reg[c]
                        + (s1_op_reg.add  ? SUM_BITS'(s1_pix_reg[c])  : '0)
                        - (s1_op_reg.drop ? SUM_BITS'(rd_data_reg[c]) : '0);
        end
    end

    // Running sums; zero them when the row is complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            em_ctl_reg <= '0;
        end
        else
        begin
            em_ctl_reg.valid <= s1_valid_reg && s1_op_reg.emit;
            em_ctl_reg.done  <= s1_op_reg.done;
            if (s1_valid_reg)
            begin
                sum_reg <= s1_op_reg.clear ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        emit_sum_reg <= sum_next;
        em_count_reg <= s1_count_reg;
    end

    // Rounded division of the window sums
    rbb_mean_div #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .MAX_RADIUS   (MAX_RADIUS)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (em_ctl_reg),
        .in_count (em_count_reg),
        .in_sum   (emit_sum_reg),
        .out_ctl  (div_ctl),
        .out_mean (div_mean)
    );

    // Result queue
    assign fifo_rd = result.valid && result.ready;

    always_ff @(posedge clk)
    begin
        if (div_ctl.valid)
        begin
            fifo_mean[tail_reg] <= div_mean;
            fifo_done[tail_reg] <= div_ctl.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (div_ctl.valid)
            begin
                tail_reg <= tail_reg + FPTR_BITS'(1);
            end
            if (fifo_rd)
            begin
                head_reg <= head_reg + FPTR_BITS'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + PEND_BITS'(div_ctl.valid) - PEND_BITS'(fifo_rd);
        end
    end

    // Present the oldest result
    assign result.valid     = fifo_cnt_reg != '0;
    assign result.red_out   = fifo_mean[head_reg][0];
    assign result.green_out = fifo_mean[head_reg][1];
    assign result.blue_out  = fifo_mean[head_reg][2];
    assign result.alpha_out = fifo_mean[head_reg][3];
    assign result.row_done  = fifo_done[head_reg];

endmodule

// File: hdl/rbb_checker.sv
// Port-level checks for the row box blur block, bound to its top level.
// Depends on row_box_blur_edge_normalized and rbb_pkg.
`timescale 1ns / 1ps

module rbb_checker #(
    parameter int CHANNEL_BITS = rbb_pkg::CHANNEL_BITS
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [CHANNEL_BITS-1:0] red_out,
    input logic [CHANNEL_BITS-1:0] green_out,
    input logic [CHANNEL_BITS-1:0] blue_out,
    input logic [CHANNEL_BITS-1:0] alpha_out,
    input logic                    row_done
);

    // No result may be offered while reset is applied
    a_quiet_in_reset: assert property (
        @(posedge clk) !rst_n |-> !result_valid
    ) else $error("result offered during reset");

    // A stalled result keeps its contents until transferred
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(alpha_out) && $stable(row_done)
    ) else $error("stalled result changed before transfer");

    // An offered result never carries undriven or unwritten bits
    a_result_known: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown({red_out, green_out, blue_out, alpha_out, row_done})
    ) else $error("result carries unknown bits");

endmodule

bind row_box_blur_edge_normalized rbb_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rbb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .red_out      (result.red_out),
    .green_out    (result.green_out),
    .blue_out     (result.blue_out),
    .alpha_out    (result.alpha_out),
    .row_done     (result.row_done)
);
